// File: hw/rtl/sswq_pkg.sv
// Sorted sleep/wake queue: shared types and codes.
// Used by the cell, the top level and the port checker. No dependencies.

package sswq_pkg;

	localparam int TASK_W = 8;
	localparam int TIME_W = 32;

	// at most this many wake-ups reported per tick
	localparam int MAX_WAKE = 16;
	localparam int WCNT_W   = $clog2(MAX_WAKE);

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_SLEEP = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] KIND_WOKEN     = 2'd0;
	localparam logic [1:0] KIND_SLEEP_ACK = 2'd1;
	localparam logic [1:0] KIND_QUERY     = 2'd2;
	localparam logic [1:0] KIND_IDLE_TICK = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [TASK_W-1:0] tid;
		logic [TIME_W-1:0] wake;
	} entry_t;

	localparam entry_t ENTRY_NONE = '{valid: 1'b0, tid: '0, wake: '0};

	typedef enum logic [1:0] {
		CH_HOLD,
		CH_INSERT,
		CH_SHIFT
	} chain_op_t;

	typedef struct packed {
		chain_op_t         op;
		logic [TASK_W-1:0] tid;
		logic [TIME_W-1:0] wake;
	} chain_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SLEEP,
		ST_QUERY,
		ST_QDONE
	} state_t;

endpackage

// File: hw/rtl/sorted_sleep_wakeup_queue.sv
// Sorted sleep/wake queue top level: tick counter, control FSM, cell chain.
// Depends on sswq_pkg and sswq_cell.
//
//   channel | valid    | ready     | payload
//   in      | in_valid | in_ready  | opcode, task_id, duration
//   out     | out_valid| out_ready | result_kind, result_task, remaining, table_full, last_of_run
//
// Tick: accepted, then one result per woken task (min 1 result).
// Sleep: one acknowledge result. Query: answered after rotating the whole
// cell chain once past the head cell. Unknown opcode: accepted, no result.
// Reset clears the tick counter and the cell valid bits at once.
// A stalled out channel holds the FSM in the tick, sleep and query-done states; one result waits in the out register.

module sorted_sleep_wakeup_queue import sswq_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [TASK_W-1:0] task_id,
	input  logic [TIME_W-1:0] duration,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        result_kind,
	output logic [TASK_W-1:0] result_task,
	output logic [TIME_W-1:0] remaining,
	output logic              table_full,
	output logic              last_of_run
);

	localparam int ROT_W = $clog2(NUM_SLOTS);

	state_t            state_q, state_d;
	logic [TIME_W-1:0] tick_q;
	logic [TASK_W-1:0] cmd_tid_q;
	logic [TIME_W-1:0] cmd_wake_q;
	logic [ROT_W-1:0]  rot_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic              found_q;
	logic [TIME_W-1:0] found_wake_q;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [TASK_W-1:0] rtask_q;
	logic [TIME_W-1:0] rem_q;
	logic              full_q;
	logic              last_q;

	entry_t      cell_ent [NUM_SLOTS];
	logic        cell_ge  [NUM_SLOTS];
	entry_t      prev_ent [NUM_SLOTS];
	logic        prev_ge  [NUM_SLOTS];
	entry_t      next_ent [NUM_SLOTS];
	chain_ctrl_t ctrl;
	entry_t      tail_in;

	logic              in_fire;
	logic              out_free;
	logic              head_due;
	logic              next_due;
	logic              emit;
	logic [1:0]        kind_d;
	logic [TASK_W-1:0] rtask_d;
	logic [TIME_W-1:0] rem_d;
	logic              full_d;
	logic              last_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign head_due  = cell_ent[0].valid && (cell_ent[0].wake <= tick_q);
	assign next_due  = cell_ent[1].valid && (cell_ent[1].wake <= tick_q);

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign result_task = rtask_q;
	assign remaining   = rem_q;
	assign table_full  = full_q;
	assign last_of_run = last_q;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_ent[i] = ENTRY_NONE;
			assign prev_ge[i]  = 1'b0;
		end else begin : g_mid
			assign prev_ent[i] = cell_ent[i-1];
			assign prev_ge[i]  = cell_ge[i-1];
		end
		if (i == NUM_SLOTS - 1) begin : g_last
			assign next_ent[i] = tail_in;
		end else begin : g_inner
			assign next_ent[i] = cell_ent[i+1];
		end

		sswq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.prev_ent (prev_ent[i]),
			.prev_ge  (prev_ge[i]),
			.next_ent (next_ent[i]),
			.ent      (cell_ent[i]),
			.ge       (cell_ge[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (opcode)
						OP_TICK:  state_d = ST_TICK;
						OP_SLEEP: state_d = ST_SLEEP;
						OP_QUERY: state_d = ST_QUERY;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK: begin
				if (out_free && (!head_due || !next_due ||
						wcnt_q == WCNT_W'(MAX_WAKE - 1))) begin
					state_d = ST_IDLE;
				end
			end
			ST_SLEEP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_QUERY: begin
				if (rot_q == ROT_W'(NUM_SLOTS - 1)) begin
					state_d = ST_QDONE;
				end
			end
			ST_QDONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl    = '{op: CH_HOLD, tid: cmd_tid_q, wake: cmd_wake_q};
		tail_in = ENTRY_NONE;
		emit    = 1'b0;
		kind_d  = KIND_IDLE_TICK;
		rtask_d = '0;
		rem_d   = '0;
		full_d  = 1'b0;
		last_d  = 1'b1;
		case (state_q)
			ST_TICK: begin
				if (out_free) begin
					emit = 1'b1;
					if (head_due) begin
						ctrl.op = CH_SHIFT;
						kind_d  = KIND_WOKEN;
						rtask_d = cell_ent[0].tid;
						last_d  = !next_due || (wcnt_q == WCNT_W'(MAX_WAKE - 1));
					end
				end
			end
			ST_SLEEP: begin
				if (out_free) begin
					emit    = 1'b1;
					kind_d  = KIND_SLEEP_ACK;
					rtask_d = cmd_tid_q;
					full_d  = cell_ent[NUM_SLOTS-1].valid;
					if (!cell_ent[NUM_SLOTS-1].valid) begin
						ctrl.op = CH_INSERT;
					end
				end
			end
			ST_QUERY: begin
				// rotate: head wraps round to the tail
				ctrl.op = CH_SHIFT;
				tail_in = cell_ent[0];
			end
			ST_QDONE: begin
				if (out_free) begin
					emit    = 1'b1;
					kind_d  = KIND_QUERY;
					rtask_d = cmd_tid_q;
					if (found_q && (found_wake_q > tick_q)) begin
						rem_d = found_wake_q - tick_q;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
			rot_q       <= '0;
			wcnt_q      <= '0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				rot_q   <= '0;
				wcnt_q  <= '0;
				found_q <= 1'b0;
				if (opcode == OP_TICK) begin
					tick_q <= tick_q + TIME_W'(1);
				end
			end
			if (state_q == ST_QUERY) begin
				rot_q <= rot_q + ROT_W'(1);
				if (!found_q && cell_ent[0].valid && cell_ent[0].tid == cmd_tid_q) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_TICK && emit && head_due) begin
				wcnt_q <= wcnt_q + WCNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_tid_q  <= task_id;
			cmd_wake_q <= tick_q + duration;
		end
		if (state_q == ST_QUERY && !found_q && cell_ent[0].valid &&
				cell_ent[0].tid == cmd_tid_q) begin
			found_wake_q <= cell_ent[0].wake;
		end
		if (emit) begin
			kind_q  <= kind_d;
			rtask_q <= rtask_d;
			rem_q   <= rem_d;
			full_q  <= full_d;
			last_q  <= last_d;
		end
	end

endmodule

// File: hw/rtl/sswq_cell.sv
// One cell of the sorted wake chain: holds one entry, inserts or shifts.
// Depends on sswq_pkg.

module sswq_cell import sswq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  chain_ctrl_t ctrl,
	input  entry_t      prev_ent,
	input  logic        prev_ge,
	input  entry_t      next_ent,
	output entry_t      ent,
	output logic        ge
);

	logic              valid_q;
	logic [TASK_W-1:0] tid_q;
	logic [TIME_W-1:0] wake_q;
	entry_t            ent_d;

	assign ent = '{valid: valid_q, tid: tid_q, wake: wake_q};
	// empty cells sit at the tail, so ge is monotone along the chain
	assign ge  = !valid_q || (wake_q >= ctrl.wake);

	always_comb begin
		ent_d = ent;
		case (ctrl.op)
			CH_INSERT: begin
				if (ge) begin
					if (prev_ge) begin
						ent_d = prev_ent;
					end else begin
						ent_d = '{valid: 1'b1, tid: ctrl.tid, wake: ctrl.wake};
					end
				end
			end
			CH_SHIFT: begin
				ent_d = next_ent;
			end
			default: begin
				ent_d = ent;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		tid_q  <= ent_d.tid;
		wake_q <= ent_d.wake;
	end

endmodule

// File: hw/rtl/sswq_checker.sv
// Port-level checks for the sorted sleep/wake queue, bound to the top level.
// Depends on sswq_pkg and sorted_sleep_wakeup_queue.

module sswq_checker import sswq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        result_kind,
	input logic [TASK_W-1:0] result_task,
	input logic [TIME_W-1:0] remaining,
	input logic              table_full,
	input logic              last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
			$stable(result_task) && $stable(remaining) && $stable(last_of_run))
		else $error("result changed while stalled");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_IDLE_TICK |-> last_of_run && result_task == '0)
		else $error("empty tick result malformed");

	a_full_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> result_kind == KIND_SLEEP_ACK && last_of_run)
		else $error("table_full on wrong result");

	a_rem_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_QUERY |-> remaining == '0)
		else $error("remaining set outside query answer");

endmodule

bind sorted_sleep_wakeup_queue sswq_checker u_sswq_checker (.*);
